### hw/rtl/hotp_pkg.sv
// Package for the HOTP HMAC-SHA1 block: SHA-1 constants, sequencer states
// and round helper functions. No dependencies.
package hotp_pkg;

   localparam int KeyWords = 8;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 64;
   localparam int Rounds = 80;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;

   localparam logic [7:0] IPad = 8'h36;
   localparam logic [7:0] OPad = 8'h5c;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_DONE
   } state_type;

   function automatic logic [31:0] round_k(input logic [6:0] r);
      if (r < 7'd20) return 32'h5A827999;
      else if (r < 7'd40) return 32'h6ED9EBA1;
      else if (r < 7'd60) return 32'h8F1BBCDC;
      else return 32'hCA62C1D6;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      if (r < 7'd20) return (b & c) | (~b & d);
      else if (r < 7'd40) return b ^ c ^ d;
      else if (r < 7'd60) return (b & c) | (b & d) | (c & d);
      else return b ^ c ^ d;
   endfunction

endpackage

### hw/rtl/hotp_hmac_sha1_top.sv
// Top level of the HOTP HMAC-SHA1 block: key registers, block builder,
// one shared SHA-1 round unit under a sequencer. Depends on hotp_pkg.
//
// Usage: write the eight 64-bit key words through csr_we/csr_idx/csr_wdata
// while the block is idle; the 3-bit index covers all eight. An item on
// req_valid/req_ready carries a 64-bit counter. The block then runs four
// SHA-1 compressions (inner key block, inner message, outer key block,
// outer message) on one round unit that does one round per cycle.
// Each compression runs a load step, the 80 rounds and an add step;
// req_ready is low from acceptance until the result is taken. The
// result item (five digest words and the 31-bit truncated code) is
// held in output registers until rsp_ready takes it; ready returns
// high in the cycle after that. The block takes no new item until
// the result of the last one has been taken.
// Reset clears the key words to zero and returns the sequencer to idle.
module hotp_hmac_sha1_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [63:0]                        req_moving_counter,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [31:0]                        rsp_digest_a,
   output logic [31:0]                        rsp_digest_b,
   output logic [31:0]                        rsp_digest_c,
   output logic [31:0]                        rsp_digest_d,
   output logic [31:0]                        rsp_digest_e,
   output logic [30:0]                        rsp_truncated_code,
   input  logic                               csr_we,
   input  logic [hotp_pkg::CsrIdxWidth-1:0]   csr_idx,
   input  logic [hotp_pkg::CsrDataWidth-1:0]  csr_wdata
);

   hotp_pkg::state_type state_ff, state_in;
   logic [63:0]  key_ff [hotp_pkg::KeyWords];
   logic [63:0]  ctr_ff, ctr_in;
   logic [1:0]   blk_ff, blk_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic [31:0]  w_ff [16];
   logic [31:0]  w_in [16];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [159:0] h_ff, h_in;
   logic [159:0] inner_ff, inner_in;
   logic [511:0] blk_data;
   logic [7:0]   pad;
   logic [31:0]  t_sum, w_next;
   logic [159:0] dig;
   logic [3:0]   off;
   logic [31:0]  code;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hotp_pkg::KeyWords; i++) key_ff[i] <= '0;
      end else if (csr_we) begin
         key_ff[csr_idx] <= csr_wdata;
      end
   end

   always_comb begin
      pad = blk_ff[1] ? hotp_pkg::OPad : hotp_pkg::IPad;
      blk_data = '0;
      unique case (blk_ff)
         2'd1: begin
            blk_data[511:448] = ctr_ff;
            blk_data[447:440] = 8'h80;
            blk_data[15:0] = 16'd576;
         end
         2'd3: begin
            blk_data[511:352] = inner_ff;
            blk_data[351:344] = 8'h80;
            blk_data[15:0] = 16'd672;
         end
         default: begin
            for (int i = 0; i < hotp_pkg::KeyWords; i++)
               blk_data[511-64*i -: 64] = key_ff[i] ^ {8{pad}};
         end
      endcase
   end

   assign w_next = {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]} << 1 |
                   {31'd0, w_ff[13][31] ^ w_ff[8][31] ^ w_ff[2][31] ^ w_ff[0][31]};
   assign t_sum = {a_ff[26:0], a_ff[31:27]} + hotp_pkg::round_f(rnd_ff, b_ff, c_ff, d_ff)
                  + e_ff + hotp_pkg::round_k(rnd_ff) + w_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hotp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ctr_ff <= ctr_in;
      blk_ff <= blk_in;
      rnd_ff <= rnd_in;
      w_ff <= w_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      h_ff <= h_in;
      inner_ff <= inner_in;
   end

   always_comb begin
      state_in = state_ff;
      ctr_in = ctr_ff;
      blk_in = blk_ff;
      rnd_in = rnd_ff;
      w_in = w_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      h_in = h_ff;
      inner_in = inner_ff;
      unique case (state_ff)
         hotp_pkg::ST_IDLE: begin
            if (req_valid) begin
               ctr_in = req_moving_counter;
               blk_in = 2'd0;
               h_in = {hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2, hotp_pkg::H3,
                       hotp_pkg::H4};
               state_in = hotp_pkg::ST_LOAD;
            end
         end
         hotp_pkg::ST_LOAD: begin
            for (int i = 0; i < 16; i++) w_in[i] = blk_data[511-32*i -: 32];
            {a_in, b_in, c_in, d_in, e_in} = h_ff;
            rnd_in = '0;
            state_in = hotp_pkg::ST_ROUND;
         end
         hotp_pkg::ST_ROUND: begin
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
            w_in[15] = w_next;
            a_in = t_sum;
            b_in = a_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            d_in = c_ff;
            e_in = d_ff;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'(hotp_pkg::Rounds - 1)) state_in = hotp_pkg::ST_ADD;
         end
         hotp_pkg::ST_ADD: begin
            h_in = {h_ff[159:128] + a_ff, h_ff[127:96] + b_ff, h_ff[95:64] + c_ff,
                    h_ff[63:32] + d_ff, h_ff[31:0] + e_ff};
            blk_in = blk_ff + 2'd1;
            state_in = hotp_pkg::ST_LOAD;
            if (blk_ff == 2'd1) begin
               inner_in = h_in;
               h_in = {hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2, hotp_pkg::H3,
                       hotp_pkg::H4};
            end else if (blk_ff == 2'd3) begin
               state_in = hotp_pkg::ST_DONE;
            end
         end
         hotp_pkg::ST_DONE: begin
            if (rsp_ready) state_in = hotp_pkg::ST_IDLE;
         end
         default: state_in = hotp_pkg::ST_IDLE;
      endcase
   end

   assign dig = h_ff;
   assign off = dig[3:0];
   assign code = dig[159 - 8*off -: 32];

   assign req_ready = (state_ff == hotp_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == hotp_pkg::ST_DONE);
   assign rsp_digest_a = dig[159:128];
   assign rsp_digest_b = dig[127:96];
   assign rsp_digest_c = dig[95:64];
   assign rsp_digest_d = dig[63:32];
   assign rsp_digest_e = dig[31:0];
   assign rsp_truncated_code = code[30:0];

   a_rounds_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hotp_pkg::ST_ADD) |-> $past(rnd_ff) == 7'(hotp_pkg::Rounds - 1))
      else $error("round count wrong at add");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(h_ff))
      else $error("result changed while stalled");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready during result");

endmodule

### tb/sv/tb_hotp_hmac_sha1_top.sv
// Self-checking testbench for hotp_hmac_sha1_top: drives 64-bit counters, with random handshake
// gaps in most tests, and checks every digest and truncated code against a SHA-1 based predictor.
// Depends on hotp_pkg and the RTL of the block only.
module tb_hotp_hmac_sha1_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 5000;

   typedef struct packed {
      logic [31:0] digest_a;
      logic [31:0] digest_b;
      logic [31:0] digest_c;
      logic [31:0] digest_d;
      logic [31:0] digest_e;
      logic [30:0] truncated_code;
   } otp_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_moving_counter = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_a, rsp_digest_b, rsp_digest_c, rsp_digest_d, rsp_digest_e;
   logic [30:0] rsp_truncated_code;
   logic        csr_we = 1'b0;
   logic [hotp_pkg::CsrIdxWidth-1:0]  csr_idx = '0;
   logic [hotp_pkg::CsrDataWidth-1:0] csr_wdata = '0;

   logic [63:0] key_shadow [hotp_pkg::KeyWords];
   otp_result_type otp_q [$];
   int          error_count = 0;
   int          quiet_cycles = 0;
   bit          gaps_on = 1'b1;

   hotp_hmac_sha1_top u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_moving_counter,
      .rsp_valid, .rsp_ready, .rsp_digest_a, .rsp_digest_b, .rsp_digest_c,
      .rsp_digest_d, .rsp_digest_e, .rsp_truncated_code, .csr_we, .csr_idx, .csr_wdata
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [159:0] sha1_compress(input logic [159:0] h,
                                                  input logic [511:0] blk);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      a = h[159:128]; b = h[127:96]; c = h[95:64]; d = h[63:32]; e = h[31:0];
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
      for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      for (int i = 0; i < hotp_pkg::Rounds; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d; k = 32'hCA62C1D6;
         end
         t = rol(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
   endfunction

   function automatic otp_result_type hmac_otp(input logic [63:0] counter);
      logic [511:0] key_blk;
      logic [159:0] h, inner, dig, iv;
      logic [31:0]  code;
      int           off;
      otp_result_type r;
      iv = {hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2, hotp_pkg::H3, hotp_pkg::H4};
      for (int i = 0; i < hotp_pkg::KeyWords; i++) key_blk[511 - 64 * i -: 64] = key_shadow[i];
      h = sha1_compress(iv, key_blk ^ {64{hotp_pkg::IPad}});
      inner = sha1_compress(h, {counter, 8'h80, 376'b0, 64'd576});
      h = sha1_compress(iv, key_blk ^ {64{hotp_pkg::OPad}});
      dig = sha1_compress(h, {inner, 8'h80, 280'b0, 64'd672});
      off = dig[3:0];
      code = dig[159 - 8 * off -: 32];
      r.digest_a = dig[159:128];
      r.digest_b = dig[127:96];
      r.digest_c = dig[95:64];
      r.digest_d = dig[63:32];
      r.digest_e = dig[31:0];
      r.truncated_code = code[30:0];
      return r;
   endfunction

   function automatic int draw_gap();
      return gaps_on ? $urandom_range(0, 15) : 0;
   endfunction

   // Result side: random stall (when gaps are on) before each item, then hold ready until it is taken.
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         n = draw_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin
      otp_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (otp_q.size() == 0) begin
            $error("result item with no expectation waiting");
            error_count++;
         end else begin
            want = otp_q.pop_front();
            if (rsp_digest_a !== want.digest_a) begin
               $error("digest_a: expected %h, got %h", want.digest_a, rsp_digest_a);
               error_count++;
            end
            if (rsp_digest_b !== want.digest_b) begin
               $error("digest_b: expected %h, got %h", want.digest_b, rsp_digest_b);
               error_count++;
            end
            if (rsp_digest_c !== want.digest_c) begin
               $error("digest_c: expected %h, got %h", want.digest_c, rsp_digest_c);
               error_count++;
            end
            if (rsp_digest_d !== want.digest_d) begin
               $error("digest_d: expected %h, got %h", want.digest_d, rsp_digest_d);
               error_count++;
            end
            if (rsp_digest_e !== want.digest_e) begin
               $error("digest_e: expected %h, got %h", want.digest_e, rsp_digest_e);
               error_count++;
            end
            if (rsp_truncated_code !== want.truncated_code) begin
               $error("truncated_code: expected %h, got %h", want.truncated_code,
                      rsp_truncated_code);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("[hotp_hmac_sha1_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_counter(input logic [63:0] counter);
      int n;
      n = draw_gap();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_moving_counter <= counter;
      do @(posedge clock); while (!req_ready);
      otp_q.push_back(hmac_otp(counter));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (otp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] words [hotp_pkg::KeyWords]);
      for (int i = 0; i < hotp_pkg::KeyWords; i++) begin
         csr_we <= 1'b1;
         csr_idx <= hotp_pkg::CsrIdxWidth'(i);
         csr_wdata <= words[i];
         key_shadow[i] = words[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_key();
      send_counter(64'd0);
      send_counter(64'd1);
      wait_idle();
   endtask

   task automatic test_counter_extremes();
      logic [63:0] words [hotp_pkg::KeyWords];
      words = '{64'h3132333435363738, 64'h3930313233343536, 64'h3738393000000000,
                64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
      load_key(words);
      gaps_on = 1'b0;
      for (int i = 0; i < 10; i++) send_counter(64'(i));
      send_counter('1);
      send_counter(64'h8000_0000_0000_0000);
      send_counter(64'h7FFF_FFFF_FFFF_FFFF);
      send_counter(64'hAAAA_AAAA_5555_5555);
      wait_idle();
      gaps_on = 1'b1;
   endtask

   task automatic test_key_extremes();
      logic [63:0] words [hotp_pkg::KeyWords];
      foreach (words[i]) words[i] = '1;
      load_key(words);
      send_counter(64'd0);
      send_counter('1);
      wait_idle();
      foreach (words[i]) words[i] = 64'h0123_4567_89AB_CDEF ^ 64'(i);
      load_key(words);
      send_counter(64'h0000_0000_FFFF_FFFF);
      send_counter(64'hFFFF_FFFF_0000_0000);
      wait_idle();
   endtask

   task automatic test_random_keys();
      logic [63:0] words [hotp_pkg::KeyWords];
      for (int p = 0; p < 4; p++) begin
         foreach (words[i]) words[i] = {$urandom(), $urandom()};
         if (p == 1) for (int i = 3; i < hotp_pkg::KeyWords; i++) words[i] = '0;
         load_key(words);
         gaps_on = (p != 2);
         for (int n = 0; n < 320; n++) send_counter({$urandom(), $urandom()});
         wait_idle();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      foreach (key_shadow[i]) key_shadow[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_key();
      test_counter_extremes();
      test_key_extremes();
      test_random_keys();
      repeat (20) @(posedge clock);
      if (error_count == 0 && otp_q.size() == 0) begin
         $display("[hotp_hmac_sha1_top] OK");
      end else begin
         $display("[hotp_hmac_sha1_top] ERROR");
      end
      $finish;
   end
endmodule

### filelist.f
hw/rtl/hotp_pkg.sv
hw/rtl/hotp_hmac_sha1_top.sv
tb/sv/tb_hotp_hmac_sha1_top.sv
